// File: design/uart_pkg.sv
// Package for the 8250-style UART register model: register offsets, cause codes,
// the transfer and state structs and the interrupt posting helpers.
// No dependencies.
package uart_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_RX    = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [7:0] REG_DATA = 8'd0;
  localparam logic [7:0] REG_IER  = 8'd1;
  localparam logic [7:0] REG_IIR  = 8'd2;
  localparam logic [7:0] REG_LCR  = 8'd3;
  localparam logic [7:0] REG_LSR  = 8'd5;
  localparam logic [7:0] REG_SCR  = 8'd7;

  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_THRE = 2'd1;
  localparam logic [1:0] CAUSE_RDA  = 2'd2;
  localparam logic [1:0] CAUSE_RLS  = 2'd3;

  localparam logic [7:0] LSR_DR    = 8'h01;
  localparam logic [7:0] LSR_ERR   = 8'h1E;
  localparam logic [7:0] LSR_THRE  = 8'h20;
  localparam logic [7:0] LSR_RESET = 8'h60;
  localparam logic [7:0] IIR_IDLE  = 8'h01;

  localparam int unsigned ShiftW = 3;
  localparam int unsigned PaddrW = 3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] address;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
    logic       rx_more;
    logic       rx_fail;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_taken;
    logic       irq_ack;
    logic       irq_inject;
  } result_t;

  typedef struct packed {
    logic [7:0] ie;
    logic [7:0] ii;
    logic [7:0] lc;
    logic [7:0] ls;
    logic [7:0] sc;
    logic [7:0] dll;
    logic [7:0] dlm;
  } state_t;

  function automatic logic [7:0] post_cause(logic [7:0] ii, logic [1:0] cause);
    return {ii[7:3], cause, 1'b0};
  endfunction

  function automatic state_t raise_thre(state_t s);
    state_t r;
    r = s;
    r.ls = r.ls | LSR_THRE;
    if (r.ie[1]) begin
      r.ii = post_cause(r.ii, CAUSE_THRE);
    end
    return r;
  endfunction

  function automatic state_t raise_rda(state_t s);
    state_t r;
    r = s;
    r.ls = r.ls | LSR_DR;
    if (r.ie[0]) begin
      r.ii = post_cause(r.ii, CAUSE_RDA);
    end
    return r;
  endfunction

endpackage

// File: design/uart_if.sv
// Valid/ready channel interfaces for the UART register model.
// Depends on nothing; payload fields are plain vectors.
interface uart_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] address;
  logic [7:0] write_data;
  logic [7:0] rx_byte;
  logic       rx_more;
  logic       rx_fail;

  modport source (output valid, action, address, write_data, rx_byte, rx_more, rx_fail,
                  input ready);
  modport sink (input valid, action, address, write_data, rx_byte, rx_more, rx_fail,
                output ready);
endinterface

interface uart_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       rx_taken;
  logic       irq_ack;
  logic       irq_inject;

  modport source (output valid, read_data, tx_valid, tx_byte, rx_taken, irq_ack, irq_inject,
                  input ready);
  modport sink (input valid, read_data, tx_valid, tx_byte, rx_taken, irq_ack, irq_inject,
                output ready);
endinterface

// File: design/uart_apb.sv
// APB configuration port holding the address shift register.
// Depends on uart_pkg.
module uart_apb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uart_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [uart_pkg::ShiftW-1:0]   reg_shift
);

  logic sel_shift;

  assign pready    = 1'b1;
  assign sel_shift = (paddr[uart_pkg::PaddrW-1] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_shift <= '0;
    end else if (psel && penable && pwrite && pready && sel_shift) begin
      reg_shift <= pwdata[uart_pkg::ShiftW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_shift) begin
      prdata[uart_pkg::ShiftW-1:0] = reg_shift;
    end
  end

endmodule

// File: design/uart_regs.sv
// Register file of the UART: state registers and the per-transfer update logic.
// Depends on uart_pkg.
module uart_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [uart_pkg::ShiftW-1:0] reg_shift,
  input  uart_pkg::item_t             item,
  output uart_pkg::result_t           result
);

  uart_pkg::state_t state;
  uart_pkg::state_t state_next;
  logic [7:0]       idx;
  logic             dlab;

  assign idx  = item.address >> reg_shift;
  assign dlab = state.lc[7];

  always_comb begin
    uart_pkg::state_t s;
    uart_pkg::result_t r;
    s = state;
    r = '0;
    case (item.action)
      uart_pkg::ACT_READ: begin
        case (idx)
          uart_pkg::REG_DATA: begin
            if (dlab) begin
              r.read_data = s.dll;
            end else begin
              r.irq_ack = 1'b1;
              if (item.rx_fail) begin
                s.ls = s.ls | uart_pkg::LSR_ERR;
                if (s.ie[2]) begin
                  s.ii = uart_pkg::post_cause(s.ii, uart_pkg::CAUSE_RLS);
                  r.irq_inject = 1'b1;
                end
              end else begin
                r.rx_taken  = 1'b1;
                r.read_data = item.rx_byte;
                if (!item.rx_more) begin
                  s.ii = uart_pkg::IIR_IDLE;
                  s.ls = s.ls & ~uart_pkg::LSR_DR;
                end
              end
            end
          end
          uart_pkg::REG_IER: r.read_data = dlab ? s.dlm : s.ie;
          uart_pkg::REG_IIR: begin
            r.read_data = s.ii;
            if (s.ii[2:1] == uart_pkg::CAUSE_THRE) begin
              s.ii = uart_pkg::IIR_IDLE;
              r.irq_ack = 1'b1;
            end
          end
          uart_pkg::REG_LCR: r.read_data = s.lc;
          uart_pkg::REG_LSR: begin
            r.read_data = s.ls;
            s.ls = s.ls & ~uart_pkg::LSR_ERR;
            if (s.ii[2:1] == uart_pkg::CAUSE_RLS) begin
              s.ii = uart_pkg::IIR_IDLE;
              r.irq_ack = 1'b1;
              if (s.ls[0]) begin
                s = uart_pkg::raise_rda(s);
                r.irq_inject = s.ie[0];
              end else begin
                s = uart_pkg::raise_thre(s);
                r.irq_inject = s.ie[1];
              end
            end
          end
          uart_pkg::REG_SCR: r.read_data = s.sc;
          default: ;
        endcase
      end
      uart_pkg::ACT_WRITE: begin
        case (idx)
          uart_pkg::REG_DATA: begin
            if (dlab) begin
              s.dll = item.write_data;
            end else begin
              r.irq_ack = 1'b1;
              if (s.ii[2:1] == uart_pkg::CAUSE_THRE) begin
                s.ii = uart_pkg::IIR_IDLE;
              end
              r.tx_valid = 1'b1;
              r.tx_byte  = item.write_data;
              if (s.ii != uart_pkg::IIR_IDLE && s.ii[2:1] == uart_pkg::CAUSE_RDA) begin
                r.irq_inject = s.ie[0];
              end else if (s.ii == uart_pkg::IIR_IDLE) begin
                s = uart_pkg::raise_thre(s);
                r.irq_inject = s.ie[1];
              end
            end
          end
          uart_pkg::REG_IER: begin
            if (dlab) begin
              s.dlm = item.write_data;
            end else begin
              s.ie = item.write_data;
              if (s.ls[0]) begin
                s = uart_pkg::raise_rda(s);
                r.irq_inject = s.ie[0];
              end else begin
                s = uart_pkg::raise_thre(s);
                r.irq_inject = s.ie[1];
              end
            end
          end
          uart_pkg::REG_LCR: s.lc = item.write_data;
          uart_pkg::REG_SCR: s.sc = item.write_data;
          default: ;
        endcase
      end
      uart_pkg::ACT_RX: begin
        s.ls = s.ls | uart_pkg::LSR_DR;
        if (s.ii[2:1] != uart_pkg::CAUSE_RLS) begin
          s = uart_pkg::raise_rda(s);
          r.irq_inject = s.ie[0];
        end
      end
      default: ;
    endcase
    state_next = s;
    result     = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.ie  <= '0;
      state.ii  <= uart_pkg::IIR_IDLE;
      state.lc  <= '0;
      state.ls  <= uart_pkg::LSR_RESET;
      state.sc  <= '0;
      state.dll <= '0;
      state.dlm <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("register state changed without a transfer");

  a_idle_has_no_cause: assert property (@(posedge clk) disable iff (rst)
    state.ii[0] |-> (state.ii[2:1] == uart_pkg::CAUSE_NONE))
    else $error("IIR shows a cause while no interrupt is pending");

  a_reset_values: assert property (@(posedge clk)
    rst |=> (state.ii == uart_pkg::IIR_IDLE && state.ls == uart_pkg::LSR_RESET))
    else $error("IIR or LSR not at reset value");

endmodule

// File: design/uart_8250_register_model_top.sv
// Top level of the 8250-style UART register model: input stage, register file,
// result stage and APB configuration port. Depends on uart_pkg, uart_if,
// uart_apb and uart_regs.
//
// Each transfer on in_ch is a bus read, a bus write or a receive notification;
// each produces exactly one transfer on out_ch with the read data, the
// transmit byte, the receive-consumed flag and the interrupt pulses.
// An accepted item is registered in the input stage, then processed against the
// register state once the result stage can take it; the state is updated and the
// result is registered at that point. The block accepts one item per cycle while
// out_ch keeps taking results.
// When out_ch stalls, the held item and the result stay put, and in_ch still
// takes one more item into the empty input stage before ready drops.
// The APB port holds reg_shift at byte addresses 0 to 3 (paddr[2] clear); write it only while idle.
// Reset is synchronous and returns the register state and the stage valid flags to
// their reset values, with IIR showing no interrupt and LSR showing the transmitter empty.
module uart_8250_register_model_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uart_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  uart_in_if.sink                     in_ch,
  uart_out_if.source                  out_ch
);

  logic                        in_q_valid;
  uart_pkg::item_t             in_q;
  uart_pkg::result_t           result;
  uart_pkg::result_t           out_q;
  logic                        out_q_valid;
  logic                        advance;
  logic                        in_take;
  logic [uart_pkg::ShiftW-1:0] reg_shift;

  assign advance      = in_q_valid && (!out_q_valid || out_ch.ready);
  assign in_ch.ready  = !in_q_valid || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  uart_apb u_apb (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .reg_shift (reg_shift)
  );

  uart_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .reg_shift (reg_shift),
    .item      (in_q),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q.action     <= in_ch.action;
      in_q.address    <= in_ch.address;
      in_q.write_data <= in_ch.write_data;
      in_q.rx_byte    <= in_ch.rx_byte;
      in_q.rx_more    <= in_ch.rx_more;
      in_q.rx_fail    <= in_ch.rx_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_q_valid <= 1'b0;
    end else if (advance) begin
      out_q_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_ch.valid      = out_q_valid;
  assign out_ch.read_data  = out_q.read_data;
  assign out_ch.tx_valid   = out_q.tx_valid;
  assign out_ch.tx_byte    = out_q.tx_byte;
  assign out_ch.rx_taken   = out_q.rx_taken;
  assign out_ch.irq_ack    = out_q.irq_ack;
  assign out_ch.irq_inject = out_q.irq_inject;

endmodule

// File: tb/tb_uart_8250_register_model_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 8250-style UART register model top level.
// A scoreboard class predicts each result transfer from the accepted items and
// checks it field by field. Depends on uart_pkg, uart_if and the top level.
module tb_uart_8250_register_model_top;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 215;
  localparam logic [7:0] REG_MCR = 8'd4;
  localparam logic [7:0] REG_MSR = 8'd6;
  localparam logic [uart_pkg::PaddrW-1:0] CFG_SHIFT_ADDR = '0;

  class uart_reg_scoreboard;
    logic [2:0] shift;
    logic [7:0] ier, iir, lcr, lsr, scr, dll, dlm;
    logic irq_pulse;
    uart_pkg::result_t expected_q[$];
    int unsigned errors;
    int unsigned printed;
    int unsigned results_seen;

    function new();
      shift = '0;
      ier = '0;
      iir = uart_pkg::IIR_IDLE;
      lcr = '0;
      lsr = uart_pkg::LSR_RESET;
      scr = '0;
      dll = '0;
      dlm = '0;
      errors = 0;
      printed = 0;
      results_seen = 0;
    endfunction

    function logic [1:0] cause();
      return iir[2:1];
    endfunction

    function void post(logic [1:0] c);
      iir = {iir[7:3], c, 1'b0};
      irq_pulse = 1'b1;
    endfunction

    function void raise_thre();
      lsr = lsr | uart_pkg::LSR_THRE;
      if (ier[1]) post(uart_pkg::CAUSE_THRE);
    endfunction

    function void raise_rda();
      lsr = lsr | uart_pkg::LSR_DR;
      if (ier[0]) post(uart_pkg::CAUSE_RDA);
    endfunction

    function void raise_rls();
      lsr = lsr | uart_pkg::LSR_ERR;
      if (ier[2]) post(uart_pkg::CAUSE_RLS);
    endfunction

    function void note_item(uart_pkg::item_t it);
      uart_pkg::result_t r;
      logic [7:0] idx;
      r = '0;
      irq_pulse = 1'b0;
      idx = it.address >> shift;
      case (it.action)
        uart_pkg::ACT_READ: begin
          case (idx)
            uart_pkg::REG_DATA: begin
              if (lcr[7]) begin
                r.read_data = dll;
              end else begin
                r.irq_ack = 1'b1;
                if (it.rx_fail) begin
                  raise_rls();
                end else begin
                  r.rx_taken = 1'b1;
                  r.read_data = it.rx_byte;
                  if (!it.rx_more) begin
                    iir = uart_pkg::IIR_IDLE;
                    lsr = lsr & ~uart_pkg::LSR_DR;
                  end
                end
              end
            end
            uart_pkg::REG_IER: r.read_data = lcr[7] ? dlm : ier;
            uart_pkg::REG_IIR: begin
              r.read_data = iir;
              if (cause() == uart_pkg::CAUSE_THRE) begin
                iir = uart_pkg::IIR_IDLE;
                r.irq_ack = 1'b1;
              end
            end
            uart_pkg::REG_LCR: r.read_data = lcr;
            uart_pkg::REG_LSR: begin
              r.read_data = lsr;
              lsr = lsr & ~uart_pkg::LSR_ERR;
              if (cause() == uart_pkg::CAUSE_RLS) begin
                iir = uart_pkg::IIR_IDLE;
                r.irq_ack = 1'b1;
                if ((lsr & uart_pkg::LSR_DR) != 8'd0) raise_rda();
                else raise_thre();
              end
            end
            uart_pkg::REG_SCR: r.read_data = scr;
            default: ;
          endcase
        end
        uart_pkg::ACT_WRITE: begin
          case (idx)
            uart_pkg::REG_DATA: begin
              if (lcr[7]) begin
                dll = it.write_data;
              end else begin
                r.irq_ack = 1'b1;
                if (cause() == uart_pkg::CAUSE_THRE) iir = uart_pkg::IIR_IDLE;
                r.tx_valid = 1'b1;
                r.tx_byte = it.write_data;
                if (iir != uart_pkg::IIR_IDLE && cause() == uart_pkg::CAUSE_RDA) begin
                  if (ier[0]) irq_pulse = 1'b1;
                end else if (iir == uart_pkg::IIR_IDLE) begin
                  raise_thre();
                end
              end
            end
            uart_pkg::REG_IER: begin
              if (lcr[7]) begin
                dlm = it.write_data;
              end else begin
                ier = it.write_data;
                if ((lsr & uart_pkg::LSR_DR) != 8'd0) raise_rda();
                else raise_thre();
              end
            end
            uart_pkg::REG_LCR: lcr = it.write_data;
            uart_pkg::REG_SCR: scr = it.write_data;
            default: ;
          endcase
        end
        uart_pkg::ACT_RX: begin
          lsr = lsr | uart_pkg::LSR_DR;
          if (cause() != uart_pkg::CAUSE_RLS) raise_rda();
        end
        default: ;
      endcase
      r.irq_inject = irq_pulse;
      expected_q.push_back(r);
    endfunction

    task report(string what);
      errors++;
      if (printed < 40) begin
        $display("[%0t] mismatch: %s", $time, what);
        printed++;
      end
    endtask

    task compare(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got 0x%02h, want 0x%02h",
                         results_seen, field, got, want));
    endtask

    task check_result(uart_pkg::result_t got);
      uart_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result transfer %0d with no item outstanding", results_seen));
      end else begin
        want = expected_q.pop_front();
        compare("read_data", got.read_data, want.read_data);
        compare("tx_valid", {7'd0, got.tx_valid}, {7'd0, want.tx_valid});
        compare("tx_byte", got.tx_byte, want.tx_byte);
        compare("rx_taken", {7'd0, got.rx_taken}, {7'd0, want.rx_taken});
        compare("irq_ack", {7'd0, got.irq_ack}, {7'd0, want.irq_ack});
        compare("irq_inject", {7'd0, got.irq_inject}, {7'd0, want.irq_inject});
      end
      results_seen++;
    endtask
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [uart_pkg::PaddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic quiet;
  logic hold_rx;
  int unsigned accepted;
  int unsigned cycle_cnt;
  uart_reg_scoreboard sb;

  uart_in_if in_ch ();
  uart_out_if out_ch ();

  uart_8250_register_model_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic uart_pkg::item_t mk(logic [1:0] act, logic [7:0] idx, logic [2:0] sh);
    uart_pkg::item_t it;
    logic [7:0] low_mask;
    low_mask = (8'd1 << sh) - 8'd1;
    it.action = act;
    it.address = (idx << sh) | (8'($urandom) & low_mask);
    it.write_data = 8'($urandom);
    it.rx_byte = 8'($urandom);
    it.rx_more = 1'($urandom);
    it.rx_fail = ($urandom_range(99) < 15);
    return it;
  endfunction

  function automatic uart_pkg::item_t rand_item(logic [2:0] sh);
    uart_pkg::item_t it;
    int unsigned pick;
    logic [1:0] act;
    logic [7:0] idx;
    pick = $urandom_range(99);
    if (pick < 3) act = uart_pkg::ACT_NONE;
    else if (pick < 18) act = uart_pkg::ACT_RX;
    else if (pick < 55) act = uart_pkg::ACT_WRITE;
    else act = uart_pkg::ACT_READ;
    idx = 8'($urandom_range(7));
    it = mk(act, idx, sh);
    if (idx == uart_pkg::REG_LCR && $urandom_range(9) < 7) it.write_data[7] = 1'b0;
    if ($urandom_range(9) == 0) it.address = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(input uart_pkg::item_t it);
    while (!quiet && $urandom_range(99) < 21) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.action <= it.action;
    in_ch.address <= it.address;
    in_ch.write_data <= it.write_data;
    in_ch.rx_byte <= it.rx_byte;
    in_ch.rx_more <= it.rx_more;
    in_ch.rx_fail <= it.rx_fail;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_item(it);
    accepted++;
  endtask

  task automatic send_dir(input logic [1:0] act, input logic [7:0] idx, input logic [7:0] data,
                          input logic more, input logic fail);
    uart_pkg::item_t it;
    it = mk(act, idx, sb.shift);
    it.write_data = data;
    it.rx_byte = data;
    it.rx_more = more;
    it.rx_fail = fail;
    send_item(it);
  endtask

  task automatic drain(input int unsigned settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_shift(input logic [2:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_SHIFT_ADDR;
    pwdata <= {29'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    sb.shift = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== {29'd0, value})
      sb.report($sformatf("reg_shift read back 0x%08h, want %0d", prdata, value));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !(hold_rx || (!quiet && $urandom_range(99) < 21));
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_result('{read_data: out_ch.read_data, tx_valid: out_ch.tx_valid,
                          tx_byte: out_ch.tx_byte, rx_taken: out_ch.rx_taken,
                          irq_ack: out_ch.irq_ack, irq_inject: out_ch.irq_inject});
    end
  end

  initial begin
    hold_rx = 1'b0;
    wait (accepted >= 600);
    hold_rx = 1'b1;
    repeat (200) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [2:0] shift_plan [6];
    int unsigned n;
    shift_plan = '{3'd5, 3'd0, 3'd3, 3'd1, 3'd4, 3'd2};
    sb = new();
    accepted = 0;
    quiet = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = uart_pkg::ACT_NONE;
    in_ch.address = '0;
    in_ch.write_data = '0;
    in_ch.rx_byte = '0;
    in_ch.rx_more = 1'b0;
    in_ch.rx_fail = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    cfg_shift(3'd0);

    send_dir(uart_pkg::ACT_READ, uart_pkg::REG_IIR, 8'h00, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_READ, uart_pkg::REG_LSR, 8'h00, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_WRITE, uart_pkg::REG_LCR, 8'h80, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_WRITE, uart_pkg::REG_DATA, 8'hFF, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_WRITE, uart_pkg::REG_IER, 8'h5A, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_READ, uart_pkg::REG_DATA, 8'h00, 1'b0, 1'b1);
    send_dir(uart_pkg::ACT_READ, uart_pkg::REG_IER, 8'h00, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_WRITE, uart_pkg::REG_LCR, 8'h03, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_WRITE, uart_pkg::REG_IER, 8'h07, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_READ, uart_pkg::REG_IIR, 8'h00, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_RX, uart_pkg::REG_DATA, 8'h00, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_READ, uart_pkg::REG_IIR, 8'h00, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_READ, uart_pkg::REG_DATA, 8'hFF, 1'b1, 1'b0);
    send_dir(uart_pkg::ACT_READ, uart_pkg::REG_DATA, 8'h00, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_READ, uart_pkg::REG_DATA, 8'h3C, 1'b0, 1'b1);
    send_dir(uart_pkg::ACT_READ, uart_pkg::REG_LSR, 8'h00, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_WRITE, uart_pkg::REG_DATA, 8'hA5, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_WRITE, uart_pkg::REG_SCR, 8'hFF, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_READ, uart_pkg::REG_SCR, 8'h00, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_WRITE, REG_MCR, 8'hFF, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_READ, REG_MSR, 8'h00, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_WRITE, uart_pkg::REG_IIR, 8'hC7, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_WRITE, uart_pkg::REG_LSR, 8'hFF, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_READ, 8'hFF, 8'h00, 1'b0, 1'b0);
    send_dir(uart_pkg::ACT_NONE, 8'hAA, 8'hFF, 1'b1, 1'b1);

    for (int p = 0; p < 6; p++) begin
      drain(4);
      cfg_shift(shift_plan[p]);
      quiet = (p == 1);
      n = 0;
      while (n < PhaseItems) begin
        if ($urandom_range(99) < 20) begin
          if ($urandom_range(1) == 0) begin
            send_item(mk(uart_pkg::ACT_RX, uart_pkg::REG_DATA, sb.shift));
            send_item(mk(uart_pkg::ACT_READ, uart_pkg::REG_IIR, sb.shift));
            send_item(mk(uart_pkg::ACT_READ, uart_pkg::REG_LSR, sb.shift));
            send_item(mk(uart_pkg::ACT_READ, uart_pkg::REG_DATA, sb.shift));
            n += 4;
          end else begin
            send_item(mk(uart_pkg::ACT_READ, uart_pkg::REG_LSR, sb.shift));
            send_item(mk(uart_pkg::ACT_WRITE, uart_pkg::REG_DATA, sb.shift));
            send_item(mk(uart_pkg::ACT_READ, uart_pkg::REG_IIR, sb.shift));
            n += 3;
          end
        end else begin
          send_item(rand_item(sb.shift));
          n++;
        end
      end
    end
    quiet = 1'b0;
    drain(8);

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
